[sv/dqi_pkg.sv]
// dqi_pkg: shared types and constants for the indexed double-ended queue.
// Used by dqi_cell and double_ended_queue_indexed_core; no dependencies.

package dqi_pkg;

    // queue geometry
    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;

    // stream packing
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 104;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         count_t;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // per-cell control from the row sequencer
    typedef struct packed {
        logic take_left;   // shift toward the back: take the front-side neighbor
        logic take_right;  // shift toward the front: take the back-side neighbor
        logic load;        // write the pushed word into this cell
        logic rd_sel;      // this cell is the requested position
        logic last_sel;    // this cell holds the last element
    } cell_ctl_t;

endpackage

[sv/double_ended_queue_indexed_core.sv]
// double_ended_queue_indexed_core: top level of the indexed double-ended queue.
// Depends on dqi_pkg and a row of dqi_cell instances.
//
// Usage:
//   A request enters on the s_ stream: s_tuser carries the kind (push back,
//   push front, pop back, pop front, read at position), s_tdata the word to
//   push and the read position. Each request gives exactly one result on the
//   m_ stream: front and back words (-1 when empty), element count, the word
//   read and a status (ok, empty on pop, full on push, position out of range).
//   Element k from the front always sits in cell k of a row of DEPTH cells;
//   a front push or pop shifts the whole row by one cell, a back push loads
//   the cell at the count, a back pop only lowers the count.
//   An accepted request first updates the row and the count, then front and
//   back are captured with the rest of the result into the output register.
//   A new request is not taken while the previous one is still pending, so
//   the block is through with the row update before it accepts the next.
//   Reset (aresetn low at a clock edge) empties the queue and drops any
//   pending result; cell contents are not cleared.
//   When the receiver holds m_tready low the result stays in the output
//   register and s_tready stays low until it is taken.

module double_ended_queue_indexed_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dqi_pkg::S_DATA_W-1:0]  s_tdata,  // value[31:0], index[35:32], zero fill
    input  logic [dqi_pkg::KIND_W-1:0]    s_tuser,  // kind[2:0]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dqi_pkg::M_DATA_W-1:0]  m_tdata   // front_value[31:0], back_value[63:32],
                                                    // count[68:64], read_value[100:69],
                                                    // status[102:101], zero fill
);
    import dqi_pkg::*;

    // request fields
    logic [KIND_W-1:0] kind;
    word_t             value;
    logic [IDX_W-1:0]  index;

    assign kind  = s_tuser;
    assign value = s_tdata[WORD_W-1:0];
    assign index = s_tdata[WORD_W +: IDX_W];

    // control and result registers
    count_t            count_reg,   count_next;
    logic              pend_reg;
    logic              m_valid_reg;
    logic [STAT_W-1:0] pend_status_reg, pend_status_next;
    word_t             pend_read_reg,   pend_read_next;
    word_t             out_front_reg, out_back_reg, out_read_reg;
    count_t            out_count_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic s_fire;
    logic push_ok, pop_ok, read_ok;

    assign s_tready = !pend_reg && (!m_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign push_ok  = count_reg < count_t'(DEPTH);
    assign pop_ok   = count_reg != '0;
    assign read_ok  = {1'b0, index} < count_reg;

    // row of cells
    cell_ctl_t ctl      [DEPTH];
    word_t     cell_q   [DEPTH];
    word_t     rd_tap   [DEPTH];
    word_t     last_tap [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_row
        word_t left_w;
        word_t right_w;

        if (i == 0) begin : g_head
            assign left_w = value;
        end else begin : g_mid_l
            assign left_w = cell_q[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        // per-cell decode of the request
        always_comb begin
            ctl[i].take_left  = s_fire && (kind == KIND_PUSH_FRONT) && push_ok;
            ctl[i].take_right = s_fire && (kind == KIND_POP_FRONT) && pop_ok;
            ctl[i].load       = s_fire && (kind == KIND_PUSH_BACK) && push_ok
                                && (count_reg == count_t'(i));
            ctl[i].rd_sel     = {1'b0, index} == count_t'(i);
            ctl[i].last_sel   = pop_ok && (count_reg - count_t'(1) == count_t'(i));
        end

        dqi_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl[i]),
            .left_word  (left_w),
            .right_word (right_w),
            .push_word  (value),
            .data_word  (cell_q[i]),
            .rd_word    (rd_tap[i]),
            .last_word  (last_tap[i])
        );
    end

    // or-reduce the one-hot taps
    word_t rd_bus, last_bus;
    always_comb begin
        rd_bus   = '0;
        last_bus = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_bus   = rd_bus | rd_tap[k];
            last_bus = last_bus | last_tap[k];
        end
    end

    // count update and status
    always_comb begin
        count_next       = count_reg;
        pend_status_next = ST_OK;
        pend_read_next   = '0;
        case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (push_ok) begin
                    count_next = count_reg + count_t'(1);
                end else begin
                    pend_status_next = ST_FULL;
                end
            end
            KIND_POP_BACK, KIND_POP_FRONT: begin
                if (pop_ok) begin
                    count_next = count_reg - count_t'(1);
                end else begin
                    pend_status_next = ST_EMPTY;
                end
            end
            KIND_READ: begin
                if (read_ok) begin
                    pend_read_next = rd_bus;
                end else begin
                    pend_status_next = ST_RANGE;
                end
            end
            default: begin
                pend_status_next = ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            pend_reg <= s_fire;
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pend_status_reg <= pend_status_next;
            pend_read_reg   <= pend_read_next;
        end
        if (pend_reg) begin
            out_front_reg  <= pop_ok ? cell_q[0] : -32'sd1;
            out_back_reg   <= pop_ok ? last_bus  : -32'sd1;
            out_count_reg  <= count_reg;
            out_read_reg   <= pend_read_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_read_reg, out_count_reg,
                       out_back_reg, out_front_reg};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= count_t'(DEPTH))
        else $error("element count above depth");

    a_fire_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> pend_reg && !s_tready)
        else $error("accepted request not pending");

    a_pend_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> m_valid_reg)
        else $error("pending result not presented");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (out_status_reg == ST_FULL) |-> out_count_reg == count_t'(DEPTH))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (out_status_reg == ST_EMPTY) |-> out_count_reg == '0)
        else $error("empty status with elements stored");

endmodule

[sv/dqi_cell.sv]
// dqi_cell: one slot of the queue row, holding the element at a fixed position.
// Depends on dqi_pkg for the word type and the cell control struct.

module dqi_cell (
    input  logic              aclk,
    input  dqi_pkg::cell_ctl_t ctl,
    input  dqi_pkg::word_t    left_word,   // neighbor toward the front
    input  dqi_pkg::word_t    right_word,  // neighbor toward the back
    input  dqi_pkg::word_t    push_word,
    output dqi_pkg::word_t    data_word,
    output dqi_pkg::word_t    rd_word,
    output dqi_pkg::word_t    last_word
);
    import dqi_pkg::*;

    word_t data_reg;
    word_t data_next;

    // shift, load or hold
    always_comb begin
        data_next = data_reg;
        if (ctl.take_left) begin
            data_next = left_word;
        end else if (ctl.take_right) begin
            data_next = right_word;
        end else if (ctl.load) begin
            data_next = push_word;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // gated taps for the read and back buses
    assign data_word = data_reg;
    assign rd_word   = ctl.rd_sel   ? data_reg : '0;
    assign last_word = ctl.last_sel ? data_reg : '0;

endmodule

[tb/sv/tb_double_ended_queue_indexed_core.sv]
`timescale 1ns / 100ps
// tb_double_ended_queue_indexed_core: self-checking bench for the indexed double-ended queue.
// Runs a directed table, then weighted random requests, against a behavioral queue model.
// Depends on dqi_pkg and double_ended_queue_indexed_core.

module tb_double_ended_queue_indexed_core;
    import dqi_pkg::*;

    // kind codes the block must treat as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int LONG_HOLD_AFTER = 300;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam word_t WORD_MAX  = 32'sh7fff_ffff;
    localparam word_t WORD_MIN  = 32'sh8000_0000;
    localparam word_t WORD_NONE = -32'sd1;

    typedef struct {
        word_t               front_value;
        word_t               back_value;
        count_t              count;
        word_t               read_value;
        logic [STAT_W-1:0]   status;
    } queue_result_t;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        word_t              value;
        logic [IDX_W-1:0]   index;
        int                 reps;
        bit                 typed;
        queue_result_t      want;
    } plan_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;

    // behavioral queue state
    word_t  shadow_ring [DEPTH];
    int     shadow_head;
    int     shadow_len;

    queue_result_t  pending_results [$];
    plan_row_t      directed_plan [$];
    int             fail_count;
    int             results_seen;

    double_ended_queue_indexed_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run limit
    initial begin
        #5_000_000;
        $display("double_ended_queue_indexed_core regression: fail");
        $finish;
    end

    function automatic queue_result_t mk_res(word_t fv, word_t bv, int cnt, word_t rv,
                                             logic [STAT_W-1:0] st);
        queue_result_t r;
        r.front_value = fv;
        r.back_value  = bv;
        r.count       = count_t'(cnt);
        r.read_value  = rv;
        r.status      = st;
        return r;
    endfunction

    // apply one request to the behavioral queue and return the expected result
    function automatic queue_result_t queue_step(logic [KIND_W-1:0] kind, word_t value,
                                                 logic [IDX_W-1:0] index);
        queue_result_t r;
        r.status     = ST_OK;
        r.read_value = '0;
        case (kind)
            KIND_PUSH_BACK: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_ring[(shadow_head + shadow_len) % DEPTH] = value;
                    shadow_len++;
                end
            end
            KIND_PUSH_FRONT: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = value;
                    shadow_len++;
                end
            end
            KIND_POP_BACK: begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else shadow_len--;
            end
            KIND_POP_FRONT: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_len--;
                end
            end
            KIND_READ: begin
                if (int'(index) >= shadow_len) r.status = ST_RANGE;
                else r.read_value = shadow_ring[(shadow_head + int'(index)) % DEPTH];
            end
            default: ;
        endcase
        r.count = count_t'(shadow_len);
        if (shadow_len == 0) begin
            r.front_value = WORD_NONE;
            r.back_value  = WORD_NONE;
        end else begin
            r.front_value = shadow_ring[shadow_head];
            r.back_value  = shadow_ring[(shadow_head + shadow_len - 1) % DEPTH];
        end
        return r;
    endfunction

    function automatic void add_row(logic [KIND_W-1:0] kind, word_t value,
                                    logic [IDX_W-1:0] index, int reps, bit typed,
                                    queue_result_t want);
        plan_row_t row;
        row.kind  = kind;
        row.value = value;
        row.index = index;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        directed_plan.push_back(row);
    endfunction

    // offer one request with a random lead-in gap, record its expected result on accept
    task automatic issue_request(logic [KIND_W-1:0] kind, word_t value,
                                 logic [IDX_W-1:0] index, bit typed, queue_result_t want);
        int gap;
        int roll;
        queue_result_t predicted;
        roll = $urandom_range(0, 99);
        if (roll < 60) gap = 0;
        else if (roll < 90) gap = $urandom_range(1, 3);
        else if (roll < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 40);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, index, value};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        predicted = queue_step(kind, value, index);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // result receiver: random backpressure plus one long hold-off
    initial begin : result_receiver
        int roll;
        int len;
        bit long_hold_done;
        long_hold_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(1, 20);
                end else if (roll < 55) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(40, 80);
                end else if (roll < 93) begin
                    m_tready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    m_tready <= 1'b0;
                    len = $urandom_range(10, 30);
                end
                repeat (len - 1) @(negedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin : result_checker
        queue_result_t seen;
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.front_value = m_tdata[31:0];
            seen.back_value  = m_tdata[63:32];
            seen.count       = m_tdata[68:64];
            seen.read_value  = m_tdata[100:69];
            seen.status      = m_tdata[102:101];
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: front %0d back %0d count %0d",
                       seen.front_value, seen.back_value, seen.count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (seen.front_value !== want.front_value) begin
                    $error("front_value: expected %0d, got %0d",
                           want.front_value, seen.front_value);
                    fail_count++;
                end
                if (seen.back_value !== want.back_value) begin
                    $error("back_value: expected %0d, got %0d",
                           want.back_value, seen.back_value);
                    fail_count++;
                end
                if (seen.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, seen.count);
                    fail_count++;
                end
                if (seen.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, seen.read_value);
                    fail_count++;
                end
                if (seen.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, seen.status);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        queue_result_t     none;
        logic [KIND_W-1:0] kind;
        word_t             value;
        logic [IDX_W-1:0]  index;
        int                push_bias;
        int                roll;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        fail_count   = 0;
        results_seen = 0;
        shadow_head  = 0;
        shadow_len   = 0;
        foreach (shadow_ring[i]) shadow_ring[i] = '0;
        none = mk_res(0, 0, 0, 0, ST_OK);

        // directed table: typed expectations where the answer is obvious
        add_row(KIND_POP_BACK,   0, 0, 1, 1, mk_res(WORD_NONE, WORD_NONE, 0, 0, ST_EMPTY));
        add_row(KIND_POP_FRONT,  0, 0, 1, 1, mk_res(WORD_NONE, WORD_NONE, 0, 0, ST_EMPTY));
        add_row(KIND_READ,       0, 0, 1, 1, mk_res(WORD_NONE, WORD_NONE, 0, 0, ST_RANGE));
        add_row(KIND_PUSH_BACK,  WORD_MAX, 0, 1, 1, mk_res(WORD_MAX, WORD_MAX, 1, 0, ST_OK));
        add_row(KIND_PUSH_FRONT, WORD_MIN, 0, 1, 1, mk_res(WORD_MIN, WORD_MAX, 2, 0, ST_OK));
        add_row(KIND_READ,       0, 0, 1, 1, mk_res(WORD_MIN, WORD_MAX, 2, WORD_MIN, ST_OK));
        add_row(KIND_READ,       0, 1, 1, 1, mk_res(WORD_MIN, WORD_MAX, 2, WORD_MAX, ST_OK));
        add_row(KIND_READ,       0, 15, 1, 1, mk_res(WORD_MIN, WORD_MAX, 2, 0, ST_RANGE));
        add_row(KIND_SPARE_LO,   0, 0, 1, 1, mk_res(WORD_MIN, WORD_MAX, 2, 0, ST_OK));
        add_row(KIND_SPARE_HI,   WORD_NONE, 15, 1, 1, mk_res(WORD_MIN, WORD_MAX, 2, 0, ST_OK));
        add_row(KIND_POP_FRONT,  0, 0, 1, 1, mk_res(WORD_MAX, WORD_MAX, 1, 0, ST_OK));
        add_row(KIND_POP_BACK,   0, 0, 1, 1, mk_res(WORD_NONE, WORD_NONE, 0, 0, ST_OK));
        // fill from the front; the last word pushed is -1
        add_row(KIND_PUSH_FRONT, 32'shffff_fff0, 0, DEPTH, 0, none);
        add_row(KIND_PUSH_BACK,  1, 0, 1, 1,
                mk_res(WORD_NONE, 32'shffff_fff0, DEPTH, 0, ST_FULL));
        add_row(KIND_PUSH_FRONT, 2, 0, 1, 1,
                mk_res(WORD_NONE, 32'shffff_fff0, DEPTH, 0, ST_FULL));
        add_row(KIND_READ,       0, 15, 1, 0, none);
        add_row(KIND_READ,       0, 7, 1, 0, none);
        add_row(KIND_POP_BACK,   0, 0, 1, 0, none);
        add_row(KIND_SPARE_MID,  32'sh1234_5678, 10, 1, 0, none);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[r]) begin
            for (int k = 0; k < directed_plan[r].reps; k++) begin
                issue_request(directed_plan[r].kind, directed_plan[r].value + k,
                              directed_plan[r].index, directed_plan[r].typed,
                              directed_plan[r].want);
            end
        end

        // random part: push bias drifts so the queue swings between empty and full
        push_bias = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_bias = 15;
                    1: push_bias = 50;
                    default: push_bias = 85;
                endcase
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: value = WORD_MAX;
                    1: value = WORD_MIN;
                    2: value = '0;
                    default: value = WORD_NONE;
                endcase
            end else begin
                value = $urandom;
            end
            index = IDX_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                kind = KIND_W'($urandom_range(5, 7));
            end else if (roll < 28) begin
                kind = KIND_READ;
                if (shadow_len > 0 && $urandom_range(0, 9) < 8)
                    index = IDX_W'($urandom_range(0, shadow_len - 1));
            end else if ($urandom_range(0, 99) < push_bias) begin
                kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
            end else begin
                kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
            end
            issue_request(kind, value, index, 1'b0, none);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0) begin
            $display("double_ended_queue_indexed_core regression: pass");
        end else begin
            $display("double_ended_queue_indexed_core regression: fail");
        end
        $finish;
    end

endmodule
